// ===== sv/cas_pkg.sv =====
// Shared constants and types for the contrast adaptive sharpening block.
package cas_pkg;
    localparam int PIX_W   = 32;
    localparam int CH_W    = 8;
    localparam int SCALE_W = 17;
    localparam int LOBE_W  = 14;
    localparam int SUM_W   = 10;
    localparam logic [SCALE_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [LOBE_W-1:0]  LOBE_LIMIT = 14'd12288;
    localparam logic [CH_W-1:0]    CH_MAX     = 8'd255;

    // Lobe divider: (bound numerator << 14) / divisor, quotient up to 16384
    localparam int LDIV_NW = 22;
    localparam int LDIV_DW = 8;
    localparam int LDIV_QW = 15;
    // Blend divider: (2*num + den) / (2*den), quotient below 1024
    localparam int BDIV_NW = 25;
    localparam int BDIV_DW = 18;
    localparam int BDIV_QW = 10;

    typedef logic [SUM_W-1:0] t_sums [3];

    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [SUM_W-1:0] sum2;
        logic [SUM_W-1:0] sum1;
        logic [SUM_W-1:0] sum0;
    } t_side_a;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [2:0]      neg;
    } t_side_c;
endpackage

// ===== sv/cas_div.sv =====
// Pipelined multi-lane restoring divider with a shared sideband.
module cas_div #(
    parameter int LANES = 1,
    parameter int NW    = 8,
    parameter int DW    = 8,
    parameter int QW    = 8,
    parameter int STEP  = 4,
    parameter int SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NW-1:0]     i_num,
    input  logic [LANES-1:0][DW-1:0]     i_den,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][QW-1:0]     o_quot,
    output logic [SW-1:0]                o_side
);
    localparam int NS = (QW + STEP - 1) / STEP;
    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [LANES-1:0][WW-1:0] w_rem_in [NS];
    logic [LANES-1:0][DW-1:0] w_den_in [NS];
    logic [LANES-1:0][QW-1:0] w_quo_in [NS];
    logic [SW-1:0]            w_side_in [NS];
    logic                     w_valid_in [NS];

    logic [LANES-1:0][WW-1:0] n_rem [NS];
    logic [LANES-1:0][QW-1:0] n_quo [NS];

    logic [LANES-1:0][WW-1:0] r_rem [NS];
    logic [LANES-1:0][DW-1:0] r_den [NS];
    logic [LANES-1:0][QW-1:0] r_quo [NS];
    logic [SW-1:0]            r_side [NS];
    logic                     r_valid [NS];

    genvar s, l;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            if (s == 0) begin : g_first
                for (l = 0; l < LANES; l++) begin : g_ln
                    assign w_rem_in[0][l] = WW'(i_num[l]);
                    assign w_quo_in[0][l] = '0;
                end
                assign w_den_in[0]   = i_den;
                assign w_side_in[0]  = i_side;
                assign w_valid_in[0] = i_valid;
            end else begin : g_next
                assign w_rem_in[s]   = r_rem[s-1];
                assign w_quo_in[s]   = r_quo[s-1];
                assign w_den_in[s]   = r_den[s-1];
                assign w_side_in[s]  = r_side[s-1];
                assign w_valid_in[s] = r_valid[s-1];
            end

            always_comb begin
                logic [WW-1:0] rem;
                logic [WW-1:0] trial;
                logic [QW-1:0] q;
                int            k;
                for (int ln = 0; ln < LANES; ln++) begin
                    rem = w_rem_in[s][ln];
                    q   = w_quo_in[s][ln];
                    for (int j = 0; j < STEP; j++) begin
                        k = QW - 1 - s * STEP - j;
                        if (k >= 0) begin
                            trial = WW'(w_den_in[s][ln]) << k;
                            if (rem >= trial) begin
                                rem  = rem - trial;
                                q[k] = 1'b1;
                            end
                        end
                    end
                    n_rem[s][ln] = rem;
                    n_quo[s][ln] = q;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else if (i_en) begin
                    r_valid[s] <= w_valid_in[s];
                end
                if (i_en) begin
                    r_rem[s]  <= n_rem[s];
                    r_quo[s]  <= n_quo[s];
                    r_den[s]  <= w_den_in[s];
                    r_side[s] <= w_side_in[s];
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[NS-1];
    assign o_quot  = r_quo[NS-1];
    assign o_side  = r_side[NS-1];
endmodule

// ===== sv/contrast_adaptive_sharpen.sv =====
// Contrast adaptive sharpening of one ARGB pixel from its cross neighborhood.
// Registers in order: stage A, lobe divider, B, M, C, blend divider, output register.
// Throughput: one pixel per cycle unless stalled; the dividers are fully pipelined.
// A stall at the output holds the whole pipeline; input ready follows output space.
// Reset clears all valid bits and sets the sharpen scale to 1.0.
module contrast_adaptive_sharpen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cas_pkg::SCALE_W-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // center_pixel, up_pixel, left_pixel, right_pixel, down_pixel
    input  logic [159:0]                s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_pixel
    output logic [31:0]                 m_axis_tdata
);
    import cas_pkg::*;

    logic en;
    logic [SCALE_W-1:0] r_scale;

    // stage A: transparency fix, min/max, channel sums, bound operands
    logic [PIX_W-1:0] w_ctr;
    logic [PIX_W-1:0] w_nb [4];
    logic [5:0][LDIV_NW-1:0] n_a_num;
    logic [5:0][LDIV_DW-1:0] n_a_den;
    t_sums n_a_sum;
    logic r_a_valid;
    logic [5:0][LDIV_NW-1:0] r_a_num;
    logic [5:0][LDIV_DW-1:0] r_a_den;
    t_side_a r_a_side;

    logic d1_valid;
    logic [5:0][LDIV_QW-1:0] d1_quot;
    t_side_a d1_side;

    logic r_b_valid;
    logic [LOBE_W-1:0] n_b_lobe, r_b_lobe;
    t_side_a r_b_side;

    logic r_m_valid;
    logic [LOBE_W-1:0] r_m_lmag;
    t_side_a r_m_side;
    logic [LOBE_W+SCALE_W-1:0] w_prod;

    logic r_c_valid;
    logic [2:0][BDIV_NW-1:0] n_c_num, r_c_num;
    logic [2:0][BDIV_DW-1:0] n_c_den, r_c_den;
    t_side_c n_c_side, r_c_side;

    logic d2_valid;
    logic [2:0][BDIV_QW-1:0] d2_quot;
    t_side_c d2_side;

    logic r_out_valid;
    logic [PIX_W-1:0] n_out, r_out;

    assign en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ONE_Q16;
        end else if (i_cfg_we) begin
            r_scale <= (i_cfg_wdata > ONE_Q16) ? ONE_Q16 : i_cfg_wdata;
        end
    end

    assign w_ctr = s_axis_tdata[31:0];

    always_comb begin
        logic [CH_W-1:0] v, mn, mx;
        logic [SUM_W-1:0] sm;
        for (int i = 0; i < 4; i++) begin
            w_nb[i] = (s_axis_tdata[32*i+63 -: 8] == '0) ? w_ctr : s_axis_tdata[32*i+32 +: 32];
        end
        for (int c = 0; c < 3; c++) begin
            mn = CH_MAX;
            mx = '0;
            sm = '0;
            for (int i = 0; i < 4; i++) begin
                v  = w_nb[i][8*c +: 8];
                mn = (v < mn) ? v : mn;
                mx = (v > mx) ? v : mx;
                sm = sm + SUM_W'(v);
            end
            n_a_sum[c] = sm;
            if (mx == '0) begin
                n_a_num[2*c] = '0;
                n_a_den[2*c] = 8'd1;
            end else begin
                n_a_num[2*c] = {mn, 14'd0};
                n_a_den[2*c] = mx;
            end
            if (mn == CH_MAX) begin
                n_a_num[2*c+1] = '0;
                n_a_den[2*c+1] = 8'd1;
            end else begin
                n_a_num[2*c+1] = {CH_MAX - mx, 14'd0};
                n_a_den[2*c+1] = CH_MAX - mn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_a_num  <= n_a_num;
            r_a_den  <= n_a_den;
            r_a_side <= '{center: w_ctr, sum2: n_a_sum[2], sum1: n_a_sum[1],
                          sum0: n_a_sum[0]};
        end
    end

    cas_div #(
        .LANES(6), .NW(LDIV_NW), .DW(LDIV_DW), .QW(LDIV_QW), .STEP(4),
        .SW($bits(t_side_a))
    ) u_lobe_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_a_valid), .i_num(r_a_num), .i_den(r_a_den), .i_side(r_a_side),
        .o_valid(d1_valid), .o_quot(d1_quot), .o_side(d1_side)
    );

    // largest lobe = smallest magnitude, clamped to the limit
    always_comb begin
        logic [LDIV_QW-1:0] m;
        m = LDIV_QW'(LOBE_LIMIT);
        for (int i = 0; i < 6; i++) begin
            m = (d1_quot[i] < m) ? d1_quot[i] : m;
        end
        n_b_lobe = m[LOBE_W-1:0];
    end

    assign w_prod = r_b_lobe * r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= d1_valid;
            r_m_valid <= r_b_valid;
        end
        if (en) begin
            r_b_lobe <= n_b_lobe;
            r_b_side <= d1_side;
            r_m_lmag <= w_prod[LOBE_W+15:16];
            r_m_side <= r_b_side;
        end
    end

    always_comb begin
        logic signed [25:0] num;
        logic [SCALE_W-1:0] den;
        logic [SUM_W-1:0]   sm;
        logic [25:0]        nn;
        den = ONE_Q16 - {1'b0, r_m_lmag, 2'b00};
        for (int c = 0; c < 3; c++) begin
            sm = (c == 0) ? r_m_side.sum0 : (c == 1) ? r_m_side.sum1 : r_m_side.sum2;
            num = $signed({2'b00, r_m_side.center[8*c +: 8], 16'd0})
                - $signed(26'(r_m_lmag * sm));
            nn = 26'(num <<< 1) + 26'(den);
            n_c_side.neg[c] = num[25];
            n_c_num[c] = num[25] ? '0 : nn[BDIV_NW-1:0];
            n_c_den[c] = {den, 1'b0};
        end
        n_c_side.alpha = r_m_side.center[31:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_m_valid;
        end
        if (en) begin
            r_c_num  <= n_c_num;
            r_c_den  <= n_c_den;
            r_c_side <= n_c_side;
        end
    end

    cas_div #(
        .LANES(3), .NW(BDIV_NW), .DW(BDIV_DW), .QW(BDIV_QW), .STEP(4),
        .SW($bits(t_side_c))
    ) u_blend_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_c_valid), .i_num(r_c_num), .i_den(r_c_den), .i_side(r_c_side),
        .o_valid(d2_valid), .o_quot(d2_quot), .o_side(d2_side)
    );

    always_comb begin
        n_out[31:24] = d2_side.alpha;
        for (int c = 0; c < 3; c++) begin
            if (d2_side.neg[c]) begin
                n_out[8*c +: 8] = '0;
            end else if (d2_quot[c] > BDIV_QW'(CH_MAX)) begin
                n_out[8*c +: 8] = CH_MAX;
            end else begin
                n_out[8*c +: 8] = d2_quot[c][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_valid;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("output request dropped or changed under stall");
    a_lobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_lobe <= LOBE_LIMIT)
        else $error("lobe magnitude above limit");
    a_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> r_m_lmag <= LOBE_LIMIT)
        else $error("scaled lobe above limit");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output space");
endmodule
